// File: rtl/core/rrv_pkg.sv
`default_nettype none
package rrv_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam int TRIG_W       = 20;
  localparam int OUT_W        = 18;
  localparam int APB_AW       = 4;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_POINTS = 2'd3
  } rrv_reg_t;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] radius;
    logic [6:0]  points;
  } rrv_cfg_t;

  typedef struct packed {
    logic       in_range;
    logic [1:0] corner;
  } rrv_meta_t;

  typedef struct packed {
    logic       in_range;
    logic [1:0] corner;
    logic [1:0] quad;
  } rrv_tag_t;

  // atan(2^-i) in 32-bit binary angle units
  function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [CORDIC_W-1:0] a;
    unique case (i)
      5'd0:  a = 34'sh020000000;
      5'd1:  a = 34'sh012E4051E;
      5'd2:  a = 34'sh009FB385B;
      5'd3:  a = 34'sh0051111D4;
      5'd4:  a = 34'sh0028B0D43;
      5'd5:  a = 34'sh00145D7E1;
      5'd6:  a = 34'sh000A2F61E;
      5'd7:  a = 34'sh000517C55;
      5'd8:  a = 34'sh00028BE53;
      5'd9:  a = 34'sh000145F2F;
      5'd10: a = 34'sh0000A2F98;
      5'd11: a = 34'sh0000517CC;
      5'd12: a = 34'sh000028BE6;
      5'd13: a = 34'sh0000145F3;
      5'd14: a = 34'sh00000A2FA;
      5'd15: a = 34'sh00000517D;
      5'd16: a = 34'sh0000028BE;
      5'd17: a = 34'sh00000145F;
      5'd18: a = 34'sh000000A30;
      5'd19: a = 34'sh000000518;
      5'd20: a = 34'sh00000028C;
      5'd21: a = 34'sh000000146;
      5'd22: a = 34'sh0000000A3;
      5'd23: a = 34'sh000000051;
      5'd24: a = 34'sh000000029;
      5'd25: a = 34'sh000000014;
      5'd26: a = 34'sh00000000A;
      5'd27: a = 34'sh000000005;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rrv_idx_if.sv
`default_nettype none
interface rrv_idx_if;
  logic       valid;
  logic       ready;
  logic [7:0] point_index;

  modport source (output valid, output point_index, input ready);
  modport sink (input valid, input point_index, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rrv_vtx_if.sv
`default_nettype none
interface rrv_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] vertex_x;
  logic signed [17:0] vertex_y;
  logic               in_range;

  modport source (output valid, output vertex_x, output vertex_y, output in_range, input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input in_range, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rrv_front.sv
`default_nettype none
module rrv_front
  import rrv_pkg::*;
#(
  parameter int MAX_CORNER_POINTS = 64,
  parameter int ANGLE_BITS        = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [7:0]            point_index,
  input  wire rrv_cfg_t              cfg,
  output logic                       out_valid,
  output rrv_meta_t                  out_meta,
  output logic [ANGLE_BITS-1:0]      out_angle
);

  localparam int CW = $clog2(MAX_CORNER_POINTS + 1);
  localparam int LW = $clog2(MAX_CORNER_POINTS);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int IW = (CW + 2 > 8) ? CW + 2 : 8;
  localparam int QW = ANGLE_BITS - 1;
  localparam int DW = LW + 1;
  localparam int NW = LW + ANGLE_BITS;

  logic [PW-1:0] ppc_ext;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] nm1_full;
  logic [LW-1:0] nm1;
  logic [DW-1:0] divisor;
  logic [IW-1:0] idx_ext, n1, n2, n3, n4, base;
  logic [IW-1:0] local_full;
  logic [1:0]    corner;
  logic          in_range;
  logic [NW-1:0] numer;

  logic          v   [0:QW];
  rrv_meta_t     meta[0:QW];
  logic [NW-1:0] rem [0:QW];
  logic [QW-1:0] quo [0:QW];

  assign ppc_ext  = PW'(cfg.points);
  assign n_eff    = (ppc_ext > PW'(MAX_CORNER_POINTS)) ? CW'(MAX_CORNER_POINTS)
                                                       : ppc_ext[CW-1:0];
  assign nm1_full = n_eff - CW'(1);
  assign nm1      = nm1_full[LW-1:0];
  assign divisor  = {nm1, 1'b0};

  assign idx_ext = IW'(point_index);
  assign n1      = IW'(n_eff);
  assign n2      = n1 << 1;
  assign n3      = n1 + n2;
  assign n4      = n1 << 2;

  always_comb begin
    priority if (idx_ext >= n3) begin
      corner = 2'd3;
      base   = n3;
    end else if (idx_ext >= n2) begin
      corner = 2'd2;
      base   = n2;
    end else if (idx_ext >= n1) begin
      corner = 2'd1;
      base   = n1;
    end else begin
      corner = 2'd0;
      base   = '0;
    end
  end

  assign in_range   = (n_eff != '0) && (idx_ext < n4);
  assign local_full = idx_ext - base;
  // 2*local*quarter + (n-1)
  assign numer      = (NW'(local_full[LW-1:0]) << (ANGLE_BITS - 1)) + NW'(nm1);

  assign quo[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0]    <= in_valid;
      meta[0] <= '{in_range: in_range, corner: corner};
      rem[0]  <= numer;
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic [NW-1:0] dsh;
    logic          ge;
    assign dsh = NW'(divisor) << K;
    assign ge  = (rem[s] >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1]    <= v[s];
        meta[s+1] <= meta[s];
        rem[s+1]  <= ge ? (rem[s] - dsh) : rem[s];
        quo[s+1]  <= {quo[s][QW-2:0], ge};
      end
    end
  end

  logic [QW-1:0]         frac;
  logic [ANGLE_BITS-1:0] angle;

  assign frac  = (n_eff > CW'(1)) ? quo[QW] : '0;
  assign angle = (ANGLE_BITS'(meta[QW].corner) << (ANGLE_BITS - 2)) + ANGLE_BITS'(frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[QW];
      out_meta  <= meta[QW];
      out_angle <= angle;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rrv_cordic.sv
`default_nettype none
module rrv_cordic
  import rrv_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire rrv_meta_t              in_meta,
  input  wire logic [ANGLE_BITS-1:0]  angle,
  output logic                        out_valid,
  output rrv_tag_t                    out_tag,
  output logic signed [CORDIC_W-1:0]  out_x,
  output logic signed [CORDIC_W-1:0]  out_y
);

  logic [ANGLE_BITS-1:0] biased;
  logic [1:0]            quad;
  logic [ANGLE_BITS-1:0] resid;
  logic [31:0]           a32;

  // fold into [-45, 45) degrees
  assign biased = angle + ANGLE_BITS'(1 << (ANGLE_BITS - 3));
  assign quad   = biased[ANGLE_BITS-1:ANGLE_BITS-2];
  assign resid  = angle - {quad, {(ANGLE_BITS-2){1'b0}}};
  assign a32    = {resid, {(32-ANGLE_BITS){1'b0}}};

  logic                       v  [0:CORDIC_STEPS];
  rrv_tag_t                   tag[0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x  [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y  [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z  [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0]   <= in_valid;
      tag[0] <= '{in_range: in_meta.in_range, corner: in_meta.corner, quad: quad};
      x[0]   <= CORDIC_GAIN;
      y[0]   <= '0;
      z[0]   <= {{(CORDIC_W-32){a32[31]}}, a32};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CORDIC_W-1:0] xs, ys, at;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    assign at = atan_lut(5'(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1]   <= v[i];
        tag[i+1] <= tag[i];
        if (!z[i][CORDIC_W-1]) begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - at;
        end else begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + at;
        end
      end
    end
  end

  assign out_valid = v[CORDIC_STEPS];
  assign out_tag   = tag[CORDIC_STEPS];
  assign out_x     = x[CORDIC_STEPS];
  assign out_y     = y[CORDIC_STEPS];

endmodule
`default_nettype wire

// File: rtl/core/rrv_back.sv
`default_nettype none
module rrv_back
  import rrv_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire rrv_tag_t               in_tag,
  input  wire logic signed [CORDIC_W-1:0] in_x,
  input  wire logic signed [CORDIC_W-1:0] in_y,
  input  wire rrv_cfg_t               cfg,
  output logic                        out_valid,
  output logic signed [OUT_W-1:0]     vertex_x,
  output logic signed [OUT_W-1:0]     vertex_y,
  output logic                        in_range
);

  localparam int PW = TRIG_W + 17;
  localparam int SW = 22;

  // round Q30 to Q16
  logic signed [CORDIC_W-1:0] xr, yr, xq, yq;
  logic signed [TRIG_W-1:0]   c0, s0, cm, sm;

  assign xr = in_x + CORDIC_W'(8192);
  assign yr = in_y + CORDIC_W'(8192);
  assign xq = xr >>> 14;
  assign yq = yr >>> 14;
  assign c0 = xq[TRIG_W-1:0];
  assign s0 = yq[TRIG_W-1:0];

  always_comb begin
    unique case (in_tag.quad)
      2'd0: begin cm = c0;  sm = s0;  end
      2'd1: begin cm = -s0; sm = c0;  end
      2'd2: begin cm = -c0; sm = -s0; end
      default: begin cm = s0; sm = -c0; end
    endcase
  end

  logic                     v1, v2;
  rrv_meta_t                m1, m2;
  logic signed [TRIG_W-1:0] c1, s1;
  logic signed [PW-1:0]     pc, ps;
  logic signed [16:0]       r_s;

  assign r_s = $signed({1'b0, cfg.radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      m1 <= '{in_range: in_tag.in_range, corner: in_tag.corner};
      c1 <= cm;
      s1 <= sm;
      v2 <= v1;
      m2 <= m1;
      pc <= r_s * c1;
      ps <= r_s * s1;
    end
  end

  logic signed [PW-1:0] tx, ty, ox, oy;
  logic signed [SW-1:0] cx, cy, sum_x, sum_y, w_s, h_s, r_w;
  logic [OUT_W-1:0]     sat_x, sat_y;

  assign tx  = pc + PW'(32768);
  assign ty  = ps + PW'(32768);
  assign ox  = tx >>> 16;
  assign oy  = ty >>> 16;
  assign w_s = SW'(cfg.width);
  assign h_s = SW'(cfg.height);
  assign r_w = SW'(cfg.radius);

  always_comb begin
    unique case (m2.corner)
      2'd0: begin cx = w_s - r_w; cy = r_w;       end
      2'd1: begin cx = r_w;       cy = r_w;       end
      2'd2: begin cx = r_w;       cy = h_s - r_w; end
      default: begin cx = w_s - r_w; cy = h_s - r_w; end
    endcase
  end

  assign sum_x = cx + ox[SW-1:0];
  assign sum_y = cy - oy[SW-1:0];

  always_comb begin
    priority if (sum_x > SW'(131071))       sat_x = 18'h1FFFF;
    else if (sum_x < -SW'(131072))          sat_x = 18'h20000;
    else                                    sat_x = sum_x[OUT_W-1:0];
    priority if (sum_y > SW'(131071))       sat_y = 18'h1FFFF;
    else if (sum_y < -SW'(131072))          sat_y = 18'h20000;
    else                                    sat_y = sum_y[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
      in_range  <= m2.in_range;
      vertex_x  <= m2.in_range ? sat_x : '0;
      vertex_y  <= m2.in_range ? sat_y : '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rounded_rect_vertex_generator.sv
// Rounded rectangle vertex generator.
// idx_ch carries a vertex index request (point_index); vtx_ch returns one
// vertex per request: vertex_x, vertex_y (signed Q17.0, saturated) and
// in_range. Requests at or past 4*points_per_corner return (0,0), in_range low.
// Shape registers sit on the APB port: width, height, radius, points per
// corner. Write them only while no request is in flight.
// Pipeline: decode, the one-bit-per-stage angle divider (ANGLE_BITS-1
// stages), the divider output register, fold, the 28-stage CORDIC and
// three output stages.
// Throughput: one request per cycle while the receiver is not stalling.
// Reset clears all valid bits and loads the default shape (1600 x 1600,
// radius 160, 8 points per corner).
// When the receiver stalls the whole pipeline holds; idx_ch.ready drops
// only while the output register holds an untaken vertex.
`default_nettype none
module rounded_rect_vertex_generator
  import rrv_pkg::*;
#(
  parameter int MAX_CORNER_POINTS = 64,
  parameter int ANGLE_BITS        = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  rrv_idx_if.sink                 idx_ch,
  rrv_vtx_if.source               vtx_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  rrv_cfg_t cfg;
  rrv_reg_t reg_sel;
  logic     adv;

  assign reg_sel = rrv_reg_t'(paddr[APB_AW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= 16'd1600;
      cfg.height <= 16'd1600;
      cfg.radius <= 16'd160;
      cfg.points <= 7'd8;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_WIDTH:  cfg.width  <= pwdata[15:0];
        REG_HEIGHT: cfg.height <= pwdata[15:0];
        REG_RADIUS: cfg.radius <= pwdata[15:0];
        REG_POINTS: cfg.points <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = 32'(cfg.width);
      REG_HEIGHT: prdata = 32'(cfg.height);
      REG_RADIUS: prdata = 32'(cfg.radius);
      REG_POINTS: prdata = 32'(cfg.points);
    endcase
  end

  assign adv          = !vtx_ch.valid || vtx_ch.ready;
  assign idx_ch.ready = adv;

  logic                       f_valid;
  rrv_meta_t                  f_meta;
  logic [ANGLE_BITS-1:0]      f_angle;
  logic                       c_valid;
  rrv_tag_t                   c_tag;
  logic signed [CORDIC_W-1:0] c_x, c_y;

  rrv_front #(
    .MAX_CORNER_POINTS(MAX_CORNER_POINTS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(idx_ch.valid),
    .point_index(idx_ch.point_index),
    .cfg(cfg),
    .out_valid(f_valid),
    .out_meta(f_meta),
    .out_angle(f_angle)
  );

  rrv_cordic #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(f_valid),
    .in_meta(f_meta),
    .angle(f_angle),
    .out_valid(c_valid),
    .out_tag(c_tag),
    .out_x(c_x),
    .out_y(c_y)
  );

  rrv_back u_back (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(c_valid),
    .in_tag(c_tag),
    .in_x(c_x),
    .in_y(c_y),
    .cfg(cfg),
    .out_valid(vtx_ch.valid),
    .vertex_x(vtx_ch.vertex_x),
    .vertex_y(vtx_ch.vertex_y),
    .in_range(vtx_ch.in_range)
  );

endmodule
`default_nettype wire
